[hw/rtl/rau_pkg.sv]
// Shared types, constants and helpers for the rational arithmetic unit.
package rau_pkg;

   localparam int OPW    = 32;
   localparam int PROD_W = 2 * OPW;
   localparam int MAG_W  = 64;
   localparam int SH_W   = 6;
   localparam int CNT_W  = 7;

   localparam logic [MAG_W-1:0] MAX_POS = {1'b0, {(MAG_W-1){1'b1}}};

   typedef enum logic [2:0] {
      FN_ADD = 3'd0,
      FN_SUB = 3'd1,
      FN_MUL = 3'd2,
      FN_DIV = 3'd3,
      FN_RCP = 3'd4,
      FN_NEG = 3'd5,
      FN_CMP = 3'd6,
      FN_NOP = 3'd7
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_COMB,
      ST_GCD_GO,
      ST_GCD,
      ST_DIVN_GO,
      ST_DIVN,
      ST_DIVD_GO,
      ST_DIVD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic           neg;
      logic [OPW-1:0] mag;
   } opnd_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } wide_type;

   function automatic opnd_type to_opnd(input logic [31:0] v);
      opnd_type       r;
      logic [OPW-1:0] m;
      m     = v[OPW-1:0];
      r.neg = m[OPW-1];
      r.mag = m[OPW-1] ? (~m + {{(OPW-1){1'b0}}, 1'b1}) : m;
      return r;
   endfunction

endpackage

[hw/rtl/rau_mul.sv]
// Registered unsigned magnitude multiplier.
module rau_mul import rau_pkg::*; (
   input  logic              clock,
   input  logic [OPW-1:0]    x,
   input  logic [OPW-1:0]    y,
   output logic [MAG_W-1:0]  prod
);

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(x) * PROD_W'(y);
   end

   assign prod = MAG_W'(prod_ff);

endmodule

[hw/rtl/rau_gcd.sv]
// Iterative binary greatest common divisor, one step per cycle.
module rau_gcd import rau_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  x,
   input  logic [MAG_W-1:0]  y,
   output logic              done,
   output logic [MAG_W-1:0]  g
);

   logic             busy_ff;
   logic             done_ff;
   logic [MAG_W-1:0] x_ff;
   logic [MAG_W-1:0] y_ff;
   logic [MAG_W-1:0] g_ff;
   logic [SH_W-1:0]  k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (x_ff == '0 || y_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x;
         y_ff <= y;
         k_ff <= '0;
      end else if (busy_ff) begin
         if (x_ff == '0) begin
            g_ff <= y_ff << k_ff;
         end else if (y_ff == '0) begin
            g_ff <= x_ff << k_ff;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + SH_W'(1);
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

[hw/rtl/rau_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  dividend,
   input  logic [MAG_W-1:0]  divisor,
   output logic              done,
   output logic [MAG_W-1:0]  quot
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [MAG_W:0]   rem_ff;
   logic [MAG_W-1:0] q_ff;
   logic [MAG_W-1:0] dsr_ff;
   logic [MAG_W:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff[MAG_W-1:0], q_ff[MAG_W-1]};
   assign ge     = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(MAG_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
         q_ff   <= {q_ff[MAG_W-2:0], ge};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// Compare, the unused function code and results forced to 0/1 finish after the combine step;
// every other result also runs a binary GCD and then two divisions (numerator, denominator).
// Throughput: one transaction at a time; busy stays high until the strobe.
// The receiver cannot stall: rsp_valid is high for exactly one cycle.
// Reset: synchronous, active high; returns the sequencer to idle.
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_func,
   input  logic [31:0]  req_a_num,
   input  logic [31:0]  req_a_den,
   input  logic [31:0]  req_b_num,
   input  logic [31:0]  req_b_den,
   output logic         rsp_valid,
   output logic [63:0]  rsp_res_num,
   output logic [62:0]  rsp_res_den,
   output logic         rsp_is_less,
   output logic         rsp_is_equal,
   output logic         rsp_is_greater,
   output logic         rsp_zero_den,
   output logic         rsp_overflow
);

   localparam logic [OPW-1:0] ONE = {{(OPW-1){1'b0}}, 1'b1};

   state_type state_ff, state_in;

   func_type         func_ff;
   opnd_type         an_ff, ad_ff, bn_ff, bd_ff;
   wide_type         p0_ff, p1_ff, p2_ff;
   wide_type         num_ff;
   logic             neg_ff;
   logic [MAG_W-1:0] den_ff;
   logic [MAG_W-1:0] g_ff;
   logic [MAG_W-1:0] n_ff;

   logic [63:0] res_num_ff;
   logic [62:0] res_den_ff;
   logic        lt_ff, eq_ff, gt_ff, zd_ff, ov_ff;

   logic [OPW-1:0]   mul_x, mul_y;
   logic             mul_neg;
   logic [MAG_W-1:0] prod;
   logic             gcd_start, gcd_done;
   logic [MAG_W-1:0] gcd_g;
   logic             div_start, div_done;
   logic [MAG_W-1:0] div_dividend, div_quot;

   wide_type         sum;
   logic             s1_neg;
   opnd_type         an_d, ad_d, bn_d, bd_d;
   logic             cmp_az, cmp_bz;

   rau_mul u_mul (
      .clock (clock),
      .x     (mul_x),
      .y     (mul_y),
      .prod  (prod)
   );

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .x     (num_ff.mag),
      .y     (den_ff),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   // decode operands; compare treats a zero-denominator operand as 0/1
   always_comb begin
      an_d   = to_opnd(req_a_num);
      ad_d   = to_opnd(req_a_den);
      bn_d   = to_opnd(req_b_num);
      bd_d   = to_opnd(req_b_den);
      cmp_az = (func_type'(req_func) == FN_CMP) && (ad_d.mag == '0);
      cmp_bz = (func_type'(req_func) == FN_CMP) && (bd_d.mag == '0);
      if (cmp_az) begin
         an_d = '{neg: 1'b0, mag: '0};
         ad_d = '{neg: 1'b0, mag: ONE};
      end
      if (cmp_bz) begin
         bn_d = '{neg: 1'b0, mag: '0};
         bd_d = '{neg: 1'b0, mag: ONE};
      end
   end

   // signed-magnitude sum of the first two products, the second negated for subtract and compare
   always_comb begin
      s1_neg = p1_ff.neg;
      if (func_ff == FN_SUB || func_ff == FN_CMP) begin
         s1_neg = !p1_ff.neg;
      end
      if (p0_ff.neg == s1_neg) begin
         sum.neg = p0_ff.neg;
         sum.mag = p0_ff.mag + p1_ff.mag;
      end else if (p0_ff.mag >= p1_ff.mag) begin
         sum.neg = p0_ff.neg;
         sum.mag = p0_ff.mag - p1_ff.mag;
      end else begin
         sum.neg = s1_neg;
         sum.mag = p1_ff.mag - p0_ff.mag;
      end
      if (sum.mag == '0) begin
         sum.neg = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_MUL0;
         ST_MUL0:    state_in = ST_MUL1;
         ST_MUL1:    state_in = ST_MUL2;
         ST_MUL2:    state_in = ST_MUL3;
         ST_MUL3:    state_in = ST_COMB;
         ST_COMB: begin
            if (func_ff == FN_CMP || func_ff == FN_NOP || p2_ff.mag == '0 ||
                ((func_ff == FN_ADD || func_ff == FN_SUB) ? sum.mag : p0_ff.mag) == '0)
            begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_GCD_GO;
            end
         end
         ST_GCD_GO:  state_in = ST_GCD;
         ST_GCD:     if (gcd_done) state_in = ST_DIVN_GO;
         ST_DIVN_GO: state_in = ST_DIVN;
         ST_DIVN:    if (div_done) state_in = ST_DIVD_GO;
         ST_DIVD_GO: state_in = ST_DIVD;
         ST_DIVD:    if (div_done) state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // multiplier operand schedule and sub-unit starts
   always_comb begin
      mul_x        = '0;
      mul_y        = '0;
      mul_neg      = 1'b0;
      gcd_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = num_ff.mag;
      unique case (state_ff)
         ST_MUL0: begin
            case (func_ff)
               FN_MUL:  begin mul_x = an_ff.mag; mul_y = bn_ff.mag;
                              mul_neg = an_ff.neg ^ bn_ff.neg; end
               FN_RCP:  begin mul_x = ad_ff.mag; mul_y = ONE; mul_neg = ad_ff.neg; end
               FN_NEG:  begin mul_x = an_ff.mag; mul_y = ONE; mul_neg = !an_ff.neg; end
               FN_CMP:  begin mul_x = an_ff.mag; mul_y = bd_ff.mag;
                              mul_neg = an_ff.neg ^ ad_ff.neg; end
               default: begin mul_x = an_ff.mag; mul_y = bd_ff.mag;
                              mul_neg = an_ff.neg ^ bd_ff.neg; end
            endcase
         end
         ST_MUL1: begin
            mul_x = ad_ff.mag;
            mul_y = bn_ff.mag;
            if (func_ff == FN_CMP) begin
               mul_neg = bn_ff.neg ^ bd_ff.neg;
            end else begin
               mul_neg = ad_ff.neg ^ bn_ff.neg;
            end
         end
         ST_MUL2: begin
            case (func_ff)
               FN_DIV:  begin mul_x = ad_ff.mag; mul_y = bn_ff.mag;
                              mul_neg = ad_ff.neg ^ bn_ff.neg; end
               FN_RCP:  begin mul_x = an_ff.mag; mul_y = ONE; mul_neg = an_ff.neg; end
               FN_NEG:  begin mul_x = ad_ff.mag; mul_y = ONE; mul_neg = ad_ff.neg; end
               default: begin mul_x = ad_ff.mag; mul_y = bd_ff.mag;
                              mul_neg = ad_ff.neg ^ bd_ff.neg; end
            endcase
         end
         ST_GCD_GO:  gcd_start = 1'b1;
         ST_DIVN_GO: div_start = 1'b1;
         ST_DIVD_GO: begin
            div_start    = 1'b1;
            div_dividend = den_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   logic neg_q_ff;

   always_ff @(posedge clock) begin
      neg_q_ff <= mul_neg;
      unique case (state_ff)
         ST_IDLE: begin
            func_ff    <= func_type'(req_func);
            an_ff      <= an_d;
            ad_ff      <= ad_d;
            bn_ff      <= bn_d;
            bd_ff      <= bd_d;
            res_num_ff <= '0;
            res_den_ff <= 63'd1;
            lt_ff      <= 1'b0;
            eq_ff      <= 1'b0;
            gt_ff      <= 1'b0;
            zd_ff      <= 1'b0;
            ov_ff      <= 1'b0;
         end
         ST_MUL1: p0_ff <= '{neg: neg_q_ff && prod != '0, mag: prod};
         ST_MUL2: p1_ff <= '{neg: neg_q_ff && prod != '0, mag: prod};
         ST_MUL3: p2_ff <= '{neg: neg_q_ff && prod != '0, mag: prod};
         ST_COMB: begin
            den_ff <= p2_ff.mag;
            if (func_ff == FN_ADD || func_ff == FN_SUB) begin
               num_ff <= sum;
               neg_ff <= sum.neg ^ p2_ff.neg;
            end else begin
               num_ff <= p0_ff;
               neg_ff <= p0_ff.neg ^ p2_ff.neg;
            end
            if (func_ff == FN_CMP) begin
               eq_ff <= sum.mag == '0;
               lt_ff <= sum.mag != '0 && sum.neg;
               gt_ff <= sum.mag != '0 && !sum.neg;
            end else if (func_ff != FN_NOP && p2_ff.mag == '0) begin
               zd_ff <= 1'b1;
            end
         end
         ST_GCD:  if (gcd_done) g_ff <= gcd_g;
         ST_DIVN: if (div_done) n_ff <= div_quot;
         ST_DIVD: begin
            if (div_done) begin
               res_den_ff <= div_quot[62:0];
               if (!neg_ff && n_ff > MAX_POS) begin
                  res_num_ff <= MAX_POS;
                  ov_ff      <= 1'b1;
               end else begin
                  res_num_ff <= neg_ff ? (~n_ff + 64'd1) : n_ff;
               end
            end
         end
         default: ;
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_res_num    = res_num_ff;
   assign rsp_res_den    = res_den_ff;
   assign rsp_is_less    = lt_ff;
   assign rsp_is_equal   = eq_ff;
   assign rsp_is_greater = gt_ff;
   assign rsp_zero_den   = zd_ff;
   assign rsp_overflow   = ov_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_is_less, rsp_is_equal, rsp_is_greater}))
      else $error("more than one compare flag set");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_res_den != '0)
      else $error("zero result denominator");

endmodule
